>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the price level queue modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define PLQ_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/plq_pkg.sv
// ----------------------------------------------------------------------------
// plq_pkg
// types and codes shared by the price level order queue controller and
// datapath
// ----------------------------------------------------------------------------
`default_nettype none

package plq_pkg;

	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 5;
	localparam int CNT_OUT_W  = 6;
	localparam int VOL_W      = 37;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_POP    = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_TAKE   = 3'd3,
		MODE_PRUNE  = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SLOT  = 2'd2,
		ST_TAKE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_SLOT = 2'd0,
		RD_HEAD = 2'd1,
		RD_CUR  = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_PLAIN = 2'd1,
		RES_LEFT  = 2'd2,
		RES_SUM   = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic      in_load;
		logic      clr_step;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      app_a;
		logic      app_b;
		logic      unlink;
		logic      take;
		logic      prune_step;
		logic      out_load;
		res_kind_t res_kind;
		status_t   res_code;
	} plq_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              level_zero;
		logic              slot_ok;
		logic              rd_member;
		logic              rd_day;
		logic              take_over;
		logic              visit_done;
		logic              left_zero;
		logic              walk_done;
		logic              res_last;
		logic              out_free;
		logic              clr_done;
	} plq_sts_t;

endpackage

`default_nettype wire

>>> design/plq_dp.sv
// ----------------------------------------------------------------------------
// plq_dp
// slot memories, list pointers, volume and count, result and output beat
// registers of the price level order queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module plq_dp #(
	parameter int ORDER_SLOTS   = 32,
	parameter int QUANTITY_BITS = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  plq_pkg::plq_cmd_t                     cmd,
	output plq_pkg::plq_sts_t                     sts,
	input  wire [plq_pkg::MODE_W-1:0]             mode,
	input  wire [plq_pkg::SLOT_OUT_W-1:0]         order_slot,
	input  wire [QUANTITY_BITS-1:0]               quantity,
	input  wire                                   is_day,
	input  wire                                   out_ready,
	output logic                                  out_valid,
	output logic [plq_pkg::STATUS_W-1:0]          status,
	output logic [plq_pkg::SLOT_OUT_W-1:0]        order_slot_out,
	output logic [QUANTITY_BITS-1:0]              order_quantity,
	output logic [plq_pkg::VOL_W-1:0]             shares_erased,
	output logic [plq_pkg::VOL_W-1:0]             total_volume,
	output logic [plq_pkg::CNT_OUT_W-1:0]         order_count,
	output logic                                  level_empty,
	output logic [plq_pkg::SLOT_OUT_W-1:0]        front_slot,
	output logic [QUANTITY_BITS-1:0]              front_quantity,
	output logic                                  last
);

	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
	localparam int QW     = QUANTITY_BITS;
	localparam int VW     = plq_pkg::VOL_W;

	// slot memories
	logic [SLOT_W-1:0] next_mem   [ORDER_SLOTS];
	logic [SLOT_W-1:0] prev_mem   [ORDER_SLOTS];
	logic [QW-1:0]     qty_mem    [ORDER_SLOTS];
	logic              day_mem    [ORDER_SLOTS];
	logic              member_mem [ORDER_SLOTS];

	// latched input beat
	logic [plq_pkg::MODE_W-1:0] mode_q;
	logic [SLOT_W-1:0]          slot_q;
	logic                       slot_ok_q;
	logic [QW-1:0]              qty_in_q;
	logic                       day_q;

	// list state
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [VW-1:0]     vol_q;
	logic [SLOT_W-1:0] clr_q;

	// read port
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] rd_addr_q;
	logic [SLOT_W-1:0] rd_next_q;
	logic [SLOT_W-1:0] rd_prev_q;
	logic [QW-1:0]     rd_qty_q;
	logic              rd_day_q;
	logic              rd_member_q;

	// prune walk
	logic [SLOT_W-1:0] cur_q;
	logic [CNT_W-1:0]  left_q;
	logic              done_q;
	logic [VW-1:0]     erased_q;

	// pending result
	plq_pkg::status_t  res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [QW-1:0]     res_qty_q;
	logic              res_last_q;
	logic              res_sum_q;

	// output beat
	logic                             out_valid_q;
	plq_pkg::status_t                 out_status_q;
	logic [plq_pkg::SLOT_OUT_W-1:0]   out_slot_q;
	logic [QW-1:0]                    out_qty_q;
	logic [VW-1:0]                    out_erased_q;
	logic [VW-1:0]                    out_vol_q;
	logic [plq_pkg::CNT_OUT_W-1:0]    out_count_q;
	logic                             out_empty_q;
	logic [plq_pkg::SLOT_OUT_W-1:0]   out_front_slot_q;
	logic [QW-1:0]                    out_front_qty_q;
	logic                             out_last_q;

	// write ports
	logic              next_we;
	logic [SLOT_W-1:0] next_wa;
	logic [SLOT_W-1:0] next_wd;
	logic              prev_we;
	logic [SLOT_W-1:0] prev_wa;
	logic [SLOT_W-1:0] prev_wd;
	logic              qty_we;
	logic [SLOT_W-1:0] qty_wa;
	logic [QW-1:0]     qty_wd;
	logic              day_we;
	logic              member_we;
	logic [SLOT_W-1:0] member_wa;
	logic              member_wd;

	logic ul_head;
	logic ul_tail;
	logic level_zero;
	logic out_free;

	assign ul_head    = (rd_addr_q == head_q);
	assign ul_tail    = (rd_addr_q == tail_q);
	assign level_zero = (count_q == '0);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		unique case (cmd.rd_sel)
			plq_pkg::RD_SLOT: rd_addr = slot_q;
			plq_pkg::RD_HEAD: rd_addr = head_q;
			plq_pkg::RD_CUR:  rd_addr = cur_q;
			default:          rd_addr = head_q;
		endcase
	end

	always_comb begin
		next_we   = 1'b0;
		next_wa   = tail_q;
		next_wd   = slot_q;
		prev_we   = 1'b0;
		prev_wa   = slot_q;
		prev_wd   = tail_q;
		qty_we    = 1'b0;
		qty_wa    = slot_q;
		qty_wd    = qty_in_q;
		day_we    = cmd.app_a;
		member_we = 1'b0;
		member_wa = slot_q;
		member_wd = 1'b0;
		priority if (cmd.clr_step) begin
			member_we = 1'b1;
			member_wa = clr_q;
		end else if (cmd.app_a) begin
			next_we   = !level_zero;
			prev_we   = 1'b1;
			qty_we    = 1'b1;
			member_we = 1'b1;
			member_wd = 1'b1;
		end else if (cmd.app_b) begin
			next_we = 1'b1;
			next_wa = slot_q;
			next_wd = '0;
		end else if (cmd.unlink) begin
			next_we   = !ul_head;
			next_wa   = rd_prev_q;
			next_wd   = rd_next_q;
			prev_we   = !ul_tail;
			prev_wa   = rd_next_q;
			prev_wd   = rd_prev_q;
			member_we = 1'b1;
			member_wa = rd_addr_q;
		end else if (cmd.take) begin
			qty_we = 1'b1;
			qty_wa = rd_addr_q;
			qty_wd = rd_qty_q - qty_in_q;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (cmd.rd_en) begin
			rd_next_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.rd_en) begin
			rd_prev_q <= prev_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (qty_we) begin
			qty_mem[qty_wa] <= qty_wd;
		end
		if (cmd.rd_en) begin
			rd_qty_q <= qty_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (day_we) begin
			day_mem[slot_q] <= day_q;
		end
		if (cmd.rd_en) begin
			rd_day_q <= day_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (member_we) begin
			member_mem[member_wa] <= member_wd;
		end
		if (cmd.rd_en) begin
			rd_member_q <= member_mem[rd_addr];
			rd_addr_q   <= rd_addr;
		end
	end

	// list pointers, count and volume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			vol_q   <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.app_a) begin
				if (level_zero) begin
					head_q <= slot_q;
				end
				tail_q  <= slot_q;
				count_q <= count_q + 1'b1;
				vol_q   <= vol_q + VW'(qty_in_q);
			end
			if (cmd.unlink) begin
				if (count_q == CNT_W'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end else begin
					if (ul_head) begin
						head_q <= rd_next_q;
					end
					if (ul_tail) begin
						tail_q <= rd_prev_q;
					end
				end
				count_q <= count_q - 1'b1;
				vol_q   <= vol_q - VW'(rd_qty_q);
			end
			if (cmd.take) begin
				vol_q <= vol_q - VW'(qty_in_q);
			end
		end
	end

	// input latch, prune walk and pending result
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			mode_q    <= mode;
			slot_q    <= SLOT_W'(order_slot);
			slot_ok_q <= (32'(order_slot) < 32'(ORDER_SLOTS));
			qty_in_q  <= quantity;
			day_q     <= is_day;
			cur_q     <= head_q;
			left_q    <= count_q;
			erased_q  <= '0;
		end
		if (cmd.prune_step) begin
			cur_q  <= rd_next_q;
			left_q <= left_q - 1'b1;
			done_q <= ul_tail || (left_q == CNT_W'(1));
			if (rd_day_q) begin
				erased_q <= erased_q + VW'(rd_qty_q);
			end
		end
		unique case (cmd.res_kind)
			plq_pkg::RES_NONE: begin
			end
			plq_pkg::RES_PLAIN: begin
				res_status_q <= cmd.res_code;
				res_slot_q   <= '0;
				res_qty_q    <= '0;
				res_last_q   <= 1'b1;
				res_sum_q    <= 1'b0;
			end
			plq_pkg::RES_LEFT: begin
				res_status_q <= plq_pkg::ST_OK;
				res_slot_q   <= rd_addr_q;
				res_qty_q    <= rd_qty_q;
				res_last_q   <= (mode_q != plq_pkg::MODE_PRUNE);
				res_sum_q    <= 1'b0;
			end
			plq_pkg::RES_SUM: begin
				res_status_q <= plq_pkg::ST_OK;
				res_slot_q   <= '0;
				res_qty_q    <= '0;
				res_last_q   <= 1'b1;
				res_sum_q    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q     <= res_status_q;
			out_slot_q       <= plq_pkg::SLOT_OUT_W'(res_slot_q);
			out_qty_q        <= res_qty_q;
			out_erased_q     <= res_sum_q ? erased_q : '0;
			out_vol_q        <= vol_q;
			out_count_q      <= plq_pkg::CNT_OUT_W'(count_q);
			out_empty_q      <= level_zero;
			out_front_slot_q <= level_zero ? '0 : plq_pkg::SLOT_OUT_W'(head_q);
			out_front_qty_q  <= level_zero ? '0 : rd_qty_q;
			out_last_q       <= res_last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign order_slot_out = out_slot_q;
	assign order_quantity = out_qty_q;
	assign shares_erased  = out_erased_q;
	assign total_volume   = out_vol_q;
	assign order_count    = out_count_q;
	assign level_empty    = out_empty_q;
	assign front_slot     = out_front_slot_q;
	assign front_quantity = out_front_qty_q;
	assign last           = out_last_q;

	assign sts.mode       = mode_q;
	assign sts.level_zero = level_zero;
	assign sts.slot_ok    = slot_ok_q;
	assign sts.rd_member  = rd_member_q;
	assign sts.rd_day     = rd_day_q;
	assign sts.take_over  = (qty_in_q > rd_qty_q);
	assign sts.visit_done = ul_tail || (left_q == CNT_W'(1));
	assign sts.left_zero  = (left_q == '0);
	assign sts.walk_done  = done_q;
	assign sts.res_last   = res_last_q;
	assign sts.out_free   = out_free;
	assign sts.clr_done   = (clr_q == SLOT_W'(ORDER_SLOTS - 1));

	`PLQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(ORDER_SLOTS), "order count above slot count")
	`PLQ_ASSERT(a_empty_ptrs, clk, arst_n, level_zero |-> (head_q == '0 && tail_q == '0), "empty level with stale pointers")
	`PLQ_NEVER(a_unlink_empty, clk, arst_n, cmd.unlink && level_zero, "unlink on an empty level")

endmodule

`default_nettype wire

>>> design/plq_ctrl.sv
// ----------------------------------------------------------------------------
// plq_ctrl
// sequencer of the price level order queue: clearing pass, per-mode
// memory read, decision, link update and result emission
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module plq_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  plq_pkg::plq_sts_t sts,
	output plq_pkg::plq_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_FETCH  = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_APP_B  = 8'b0001_0000,
		S_HEADRD = 8'b0010_0000,
		S_SUM    = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.rd_sel   = plq_pkg::RD_HEAD;
		cmd.res_kind = plq_pkg::RES_NONE;
		cmd.res_code = plq_pkg::ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				unique case (sts.mode)
					plq_pkg::MODE_APPEND: cmd.rd_sel = plq_pkg::RD_SLOT;
					plq_pkg::MODE_REMOVE: cmd.rd_sel = plq_pkg::RD_SLOT;
					plq_pkg::MODE_PRUNE:  cmd.rd_sel = plq_pkg::RD_CUR;
					default:              cmd.rd_sel = plq_pkg::RD_HEAD;
				endcase
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d      = S_HEADRD;
				cmd.res_kind = plq_pkg::RES_PLAIN;
				unique case (sts.mode)
					plq_pkg::MODE_APPEND: begin
						if (!sts.slot_ok || sts.rd_member) begin
							cmd.res_code = plq_pkg::ST_SLOT;
						end else begin
							cmd.app_a = 1'b1;
							state_d   = S_APP_B;
						end
					end
					plq_pkg::MODE_POP: begin
						if (sts.level_zero) begin
							cmd.res_code = plq_pkg::ST_EMPTY;
						end else begin
							cmd.unlink   = 1'b1;
							cmd.res_kind = plq_pkg::RES_LEFT;
						end
					end
					plq_pkg::MODE_REMOVE: begin
						priority if (sts.level_zero) begin
							cmd.res_code = plq_pkg::ST_EMPTY;
						end else if (!sts.slot_ok || !sts.rd_member) begin
							cmd.res_code = plq_pkg::ST_SLOT;
						end else begin
							cmd.unlink   = 1'b1;
							cmd.res_kind = plq_pkg::RES_LEFT;
						end
					end
					plq_pkg::MODE_TAKE: begin
						priority if (sts.level_zero) begin
							cmd.res_code = plq_pkg::ST_EMPTY;
						end else if (sts.take_over) begin
							cmd.res_code = plq_pkg::ST_TAKE;
						end else begin
							cmd.take = 1'b1;
						end
					end
					plq_pkg::MODE_PRUNE: begin
						if (sts.left_zero) begin
							cmd.res_kind = plq_pkg::RES_SUM;
						end else begin
							cmd.prune_step = 1'b1;
							priority if (sts.rd_day) begin
								cmd.unlink   = 1'b1;
								cmd.res_kind = plq_pkg::RES_LEFT;
							end else if (sts.visit_done) begin
								cmd.res_kind = plq_pkg::RES_SUM;
							end else begin
								cmd.res_kind = plq_pkg::RES_NONE;
								state_d      = S_FETCH;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_APP_B: begin
				cmd.app_b = 1'b1;
				state_d   = S_HEADRD;
			end
			S_HEADRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = plq_pkg::RD_HEAD;
				state_d    = S_EMIT;
			end
			S_SUM: begin
				cmd.res_kind = plq_pkg::RES_SUM;
				state_d      = S_HEADRD;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					priority if (sts.res_last) begin
						state_d = S_IDLE;
					end else if (sts.walk_done) begin
						state_d = S_SUM;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	`PLQ_ASSERT(a_load_free, clk, arst_n, cmd.out_load |-> sts.out_free, "beat loaded over a waiting beat")
	`PLQ_NEVER(a_write_clash, clk, arst_n, cmd.clr_step && (cmd.app_a || cmd.unlink || cmd.in_load), "list update during clearing pass")
	`PLQ_ASSERT(a_last_idle, clk, arst_n, (cmd.out_load && sts.res_last) |=> in_ready, "final beat not followed by idle")

endmodule

`default_nettype wire

>>> design/price_level_order_queue_core.sv
// ----------------------------------------------------------------------------
// price_level_order_queue_core
// resting orders of one price level as a time-ordered doubly linked list
// over a fixed set of order slots, with volume and order count tracking
// ----------------------------------------------------------------------------
// After reset the block clears the membership bit of every slot and takes
// no beat until the clearing pass is done. Each input beat then runs alone
// through a sequencer around single-port slot memories with registered
// reads: append goes through fetch, decide, a second append step, head read
// and emit; pop, remove, take and an undefined mode skip the second step;
// prune repeats fetch and decide per order visited, with one result beat
// per removed day order and a summary beat at the end. A result waiting in
// the output register only stalls the sequencer when the next result is ready to go.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_order_queue_core #(
	parameter int ORDER_SLOTS   = 32,
	parameter int QUANTITY_BITS = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [plq_pkg::MODE_W-1:0]          mode,
	input  wire [plq_pkg::SLOT_OUT_W-1:0]      order_slot,
	input  wire [QUANTITY_BITS-1:0]            quantity,
	input  wire                                is_day,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [plq_pkg::STATUS_W-1:0]       status,
	output logic [plq_pkg::SLOT_OUT_W-1:0]     order_slot_out,
	output logic [QUANTITY_BITS-1:0]           order_quantity,
	output logic [plq_pkg::VOL_W-1:0]          shares_erased,
	output logic [plq_pkg::VOL_W-1:0]          total_volume,
	output logic [plq_pkg::CNT_OUT_W-1:0]      order_count,
	output logic                               level_empty,
	output logic [plq_pkg::SLOT_OUT_W-1:0]     front_slot,
	output logic [QUANTITY_BITS-1:0]           front_quantity,
	output logic                               last
);

	plq_pkg::plq_cmd_t cmd;
	plq_pkg::plq_sts_t sts;

	plq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plq_dp #(
		.ORDER_SLOTS   (ORDER_SLOTS),
		.QUANTITY_BITS (QUANTITY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.order_slot     (order_slot),
		.quantity       (quantity),
		.is_day         (is_day),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.order_slot_out (order_slot_out),
		.order_quantity (order_quantity),
		.shares_erased  (shares_erased),
		.total_volume   (total_volume),
		.order_count    (order_count),
		.level_empty    (level_empty),
		.front_slot     (front_slot),
		.front_quantity (front_quantity),
		.last           (last)
	);

endmodule

`default_nettype wire
